// File: sv/slot_allocator_farthest_evict_top_macros.svh
// Assertion macros shared by the slot allocator checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef SLOT_ALLOCATOR_FARTHEST_EVICT_TOP_MACROS_SVH
`define SLOT_ALLOCATOR_FARTHEST_EVICT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("safe_chk: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("safe_chk: next-cycle check failed");

`endif

// File: sv/safe_pkg.sv
// Package for the slot allocator: sizes, codes, types and field helpers.
// No dependencies; every other file of the block but the macros header imports it.
`default_nettype none

package safe_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int ID_BITS      = 10;

  localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
  localparam int MODE_W       = 2;
  localparam int COORD_W      = 32;
  localparam int ID_FIELD_W   = 10;
  localparam int SLOT_FIELD_W = 3;
  localparam int ID_WIDE      = 16;
  localparam int IDX_WIDE     = 8;

  // Distance: each axis difference is floored by 2^DIST_SHIFT before squaring.
  localparam int DIST_SHIFT   = 8;
  localparam int Q_W          = COORD_W + 1 - DIST_SHIFT;
  localparam int SQ_W         = 2 * Q_W - 1;
  localparam int DIST_W       = SQ_W + 2;

  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic [ID_BITS-1:0]        id_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [Q_W-1:0]     q_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [DIST_W-1:0]         dist_t;

  localparam mode_t MODE_REQUEST = 2'd0;
  localparam mode_t MODE_RELEASE = 2'd1;
  localparam mode_t MODE_UPDATE  = 2'd2;

  typedef struct packed {
    logic   valid;
    id_t    owner;
    coord_t px;
    coord_t py;
    coord_t pz;
  } slot_t;

  typedef struct packed {
    logic is_req;
    idx_t idx;
    id_t  owner;
  } dist_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic id_t id_of(input logic [ID_FIELD_W-1:0] f);
    logic [ID_WIDE-1:0] t;
    id_t                r;
    t = ID_WIDE'(f);
    for (int i = 0; i < ID_BITS; i++) begin
      r[i] = t[i];
    end
    return r;
  endfunction

  function automatic logic [ID_FIELD_W-1:0] id_field(input id_t v);
    logic [ID_WIDE-1:0] t;
    t = '0;
    for (int i = 0; i < ID_BITS; i++) begin
      t[i] = v[i];
    end
    return t[ID_FIELD_W-1:0];
  endfunction

  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input idx_t v);
    logic [IDX_WIDE-1:0] t;
    t = '0;
    for (int i = 0; i < IDX_W; i++) begin
      t[i] = v[i];
    end
    return t[SLOT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/safe_if.sv
// Request and result channel interfaces of the slot allocator.
// Depends on safe_pkg for field widths.
`default_nettype none

interface safe_in_if;
  import safe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [ID_FIELD_W-1:0]   item_id;
  logic                    force_evict;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] view_x;
  logic signed [COORD_W-1:0] view_y;
  logic signed [COORD_W-1:0] view_z;

  modport source (
    output valid, mode, item_id, force_evict, pos_x, pos_y, pos_z,
           view_x, view_y, view_z,
    input  ready
  );
  modport sink (
    input  valid, mode, item_id, force_evict, pos_x, pos_y, pos_z,
           view_x, view_y, view_z,
    output ready
  );
endinterface

interface safe_out_if;
  import safe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    was_resident;
  logic [SLOT_FIELD_W-1:0] slot_index;
  logic                    evicted;
  logic [ID_FIELD_W-1:0]   evicted_item;

  modport source (
    output valid, accepted, was_resident, slot_index, evicted, evicted_item,
    input  ready
  );
  modport sink (
    input  valid, accepted, was_resident, slot_index, evicted, evicted_item,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/safe_cell.sv
// One slot of the allocator table, a link in the rotating ring of cells.
// Depends on safe_pkg for the slot record type.
`default_nettype none

module safe_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           wr_en,
  input  safe_pkg::slot_t nbr_in,
  input  safe_pkg::slot_t wr_data,
  output safe_pkg::slot_t q
);
  import safe_pkg::*;

  logic   valid_r, valid_nxt;
  id_t    owner_r, owner_nxt;
  coord_t px_r, px_nxt;
  coord_t py_r, py_nxt;
  coord_t pz_r, pz_nxt;

  // A write lands in place; otherwise the ring moves one step when enabled.
  always_comb begin
    valid_nxt = valid_r;
    owner_nxt = owner_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pz_nxt    = pz_r;
    if (wr_en) begin
      valid_nxt = wr_data.valid;
      owner_nxt = wr_data.owner;
      px_nxt    = wr_data.px;
      py_nxt    = wr_data.py;
      pz_nxt    = wr_data.pz;
    end else if (shift_en) begin
      valid_nxt = nbr_in.valid;
      owner_nxt = nbr_in.owner;
      px_nxt    = nbr_in.px;
      py_nxt    = nbr_in.py;
      pz_nxt    = nbr_in.pz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
  end

  assign q = {valid_r, owner_r, px_r, py_r, pz_r};

endmodule

`default_nettype wire

// File: sv/safe_dist.sv
// Three-stage distance pipeline: floored axis differences, squares, sum.
// Depends on safe_pkg for coordinate, distance and tag types.
`default_nettype none

module safe_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  safe_pkg::dist_tag_t in_tag,
  input  safe_pkg::coord_t    p_x,
  input  safe_pkg::coord_t    p_y,
  input  safe_pkg::coord_t    p_z,
  input  safe_pkg::coord_t    v_x,
  input  safe_pkg::coord_t    v_y,
  input  safe_pkg::coord_t    v_z,
  output logic                out_vld,
  output safe_pkg::dist_tag_t out_tag,
  output safe_pkg::dist_t     out_dist,
  output logic                busy
);
  import safe_pkg::*;

  logic                   vld1_r, vld2_r, vld3_r;
  dist_tag_t              tag1_r, tag2_r, tag3_r;
  q_t                     qx_r, qy_r, qz_r;
  q_t                     qx_nxt, qy_nxt, qz_nxt;
  sq_t                    sqx_r, sqy_r, sqz_r;
  dist_t                  dist_r, dist_nxt;
  logic [COORD_W:0]       dx, dy, dz;
  logic signed [2*Q_W-1:0] prod_x, prod_y, prod_z;

  // The exact 33-bit difference, then an arithmetic shift by dropping low bits.
  always_comb begin
    dx     = {p_x[COORD_W-1], p_x} - {v_x[COORD_W-1], v_x};
    dy     = {p_y[COORD_W-1], p_y} - {v_y[COORD_W-1], v_y};
    dz     = {p_z[COORD_W-1], p_z} - {v_z[COORD_W-1], v_z};
    qx_nxt = dx[COORD_W:DIST_SHIFT];
    qy_nxt = dy[COORD_W:DIST_SHIFT];
    qz_nxt = dz[COORD_W:DIST_SHIFT];
  end

  always_comb begin
    prod_x   = qx_r * qx_r;
    prod_y   = qy_r * qy_r;
    prod_z   = qz_r * qz_r;
    dist_nxt = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    qz_r   <= qz_nxt;
    tag2_r <= tag1_r;
    sqx_r  <= prod_x[SQ_W-1:0];
    sqy_r  <= prod_y[SQ_W-1:0];
    sqz_r  <= prod_z[SQ_W-1:0];
    tag3_r <= tag2_r;
    dist_r <= dist_nxt;
  end

  assign out_vld  = vld3_r;
  assign out_tag  = tag3_r;
  assign out_dist = dist_r;
  assign busy     = vld1_r | vld2_r | vld3_r;

endmodule

`default_nettype wire

// File: sv/slot_allocator_farthest_evict_top.sv
// Slot allocator with farthest-occupant eviction, built as a ring of slot cells.
// A result is registered once the ring has turned and the distance pipeline has drained.
// A new request is taken only in IDLE, after the last one is done; this is set by one full
// rotation of the cell ring past the single distance pipeline plus its three-stage drain.
// Reset (synchronous, active low) empties every slot and the result register.
// Depends on safe_pkg, safe_if, safe_cell and safe_dist.
`default_nettype none

module slot_allocator_farthest_evict_top (
  input  logic       clk,
  input  logic       rst_n,
  safe_in_if.sink    in_ch,
  safe_out_if.source out_ch
);
  import safe_pkg::*;

  // Sequencer state and the scan counter, which also names the slot at the ring head.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             commit;

  // The request being worked on, captured when it is accepted.
  mode_t  mode_r;
  id_t    id_r;
  logic   force_r;
  coord_t px_r, py_r, pz_r;
  coord_t vx_r, vy_r, vz_r;

  // Scan results gathered as the slots pass the head of the ring.
  logic  match_found_r, free_found_r, vic_found_r;
  idx_t  match_idx_r, free_idx_r, vic_idx_r;
  id_t   vic_owner_r;
  dist_t best_r;

  // Ring of cells. Cell 0 is the head; every cell takes its right neighbor on a shift,
  // so after SLOT_COUNT shifts each slot is back in its own cell.
  slot_t                 cell_q [SLOT_COUNT];
  slot_t                 wr_data;
  logic [SLOT_COUNT-1:0] wr_en;
  logic                  shift_en;

  // Distance pipeline feed and output.
  logic      dist_in_vld;
  dist_tag_t dist_in_tag;
  coord_t    dist_px, dist_py, dist_pz;
  coord_t    dist_vx, dist_vy, dist_vz;
  logic      dist_out_vld;
  dist_tag_t dist_out_tag;
  dist_t     dist_out;
  logic      dist_busy;

  // Decision made once the scan has drained.
  logic  dec_acc, dec_res, dec_ev, dec_wr;
  idx_t  dec_slot;
  id_t   dec_evid;

  // Result register.
  logic                    out_valid_r;
  logic                    out_acc_r, out_res_r, out_ev_r;
  logic [SLOT_FIELD_W-1:0] out_slot_r;
  logic [ID_FIELD_W-1:0]   out_evid_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign shift_en    = (state_r == ST_SCAN);

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      id_r    <= id_of(in_ch.item_id);
      force_r <= in_ch.force_evict;
      px_r    <= in_ch.pos_x;
      py_r    <= in_ch.pos_y;
      pz_r    <= in_ch.pos_z;
      vx_r    <= in_ch.view_x;
      vy_r    <= in_ch.view_y;
      vz_r    <= in_ch.view_z;
    end
  end

  // Sequencer: the ring turns once in SCAN, DRAIN waits for the last distance,
  // DONE writes the table and loads the result once the result register is free.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The requester's own distance enters the pipeline in the accept cycle, ahead of
  // every slot, so it sets the eviction threshold before any slot is compared.
  always_comb begin
    if (state_r == ST_IDLE) begin
      dist_in_vld = accept;
      dist_in_tag = '{is_req: 1'b1, idx: '0, owner: '0};
      dist_px     = in_ch.pos_x;
      dist_py     = in_ch.pos_y;
      dist_pz     = in_ch.pos_z;
      dist_vx     = in_ch.view_x;
      dist_vy     = in_ch.view_y;
      dist_vz     = in_ch.view_z;
    end else begin
      dist_in_vld = (state_r == ST_SCAN);
      dist_in_tag = '{is_req: 1'b0, idx: cnt_r[IDX_W-1:0], owner: cell_q[0].owner};
      dist_px     = cell_q[0].px;
      dist_py     = cell_q[0].py;
      dist_pz     = cell_q[0].pz;
      dist_vx     = vx_r;
      dist_vy     = vy_r;
      dist_vz     = vz_r;
    end
  end

  safe_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (dist_in_vld),
    .in_tag   (dist_in_tag),
    .p_x      (dist_px),
    .p_y      (dist_py),
    .p_z      (dist_pz),
    .v_x      (dist_vx),
    .v_y      (dist_vy),
    .v_z      (dist_vz),
    .out_vld  (dist_out_vld),
    .out_tag  (dist_out_tag),
    .out_dist (dist_out),
    .busy     (dist_busy)
  );

  // Id lookup and lowest free slot, checked at the ring head in slot order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (accept) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (!match_found_r && cell_q[0].valid && (cell_q[0].owner == id_r)) begin
        match_found_r <= 1'b1;
      end
      if (!free_found_r && !cell_q[0].valid) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      if (!match_found_r && cell_q[0].valid && (cell_q[0].owner == id_r)) begin
        match_idx_r <= cnt_r[IDX_W-1:0];
      end
      if (!free_found_r && !cell_q[0].valid) begin
        free_idx_r <= cnt_r[IDX_W-1:0];
      end
    end
  end

  // Farthest-occupant search. Only a strictly larger distance takes over, so ties
  // keep the lowest slot. The result matters only when every slot is occupied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vic_found_r <= 1'b0;
    end else if (dist_out_vld) begin
      if (dist_out_tag.is_req) begin
        vic_found_r <= 1'b0;
      end else if (dist_out > best_r) begin
        vic_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_out_vld) begin
      if (dist_out_tag.is_req) begin
        best_r <= force_r ? '0 : dist_out;
      end else if (dist_out > best_r) begin
        best_r      <= dist_out;
        vic_idx_r   <= dist_out_tag.idx;
        vic_owner_r <= dist_out_tag.owner;
      end
    end
  end

  // Outcome of the request. A refused or unknown request leaves everything at zero.
  always_comb begin
    dec_acc  = 1'b0;
    dec_res  = 1'b0;
    dec_ev   = 1'b0;
    dec_wr   = 1'b0;
    dec_slot = '0;
    dec_evid = '0;
    case (mode_r)
      MODE_REQUEST: begin
        if (match_found_r) begin
          dec_acc  = 1'b1;
          dec_res  = 1'b1;
          dec_slot = match_idx_r;
        end else if (free_found_r) begin
          dec_acc  = 1'b1;
          dec_wr   = 1'b1;
          dec_slot = free_idx_r;
        end else if (vic_found_r) begin
          dec_acc  = 1'b1;
          dec_wr   = 1'b1;
          dec_ev   = 1'b1;
          dec_slot = vic_idx_r;
          dec_evid = vic_owner_r;
        end
      end
      MODE_RELEASE, MODE_UPDATE: begin
        if (match_found_r) begin
          dec_acc  = 1'b1;
          dec_wr   = 1'b1;
          dec_slot = match_idx_r;
        end
      end
      default: begin
        dec_acc = 1'b0;
      end
    endcase
  end

  // A grant or an update writes the new owner and position; a release clears valid.
  // An update's owner is the requested id, so the same record serves all three.
  assign wr_data = {(mode_r != MODE_RELEASE), id_r, px_r, py_r, pz_r};

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    assign wr_en[i] = commit && dec_wr && (dec_slot == IDX_W'(i));

    safe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .wr_en    (wr_en[i]),
      .nbr_in   (cell_q[(i + 1) % SLOT_COUNT]),
      .wr_data  (wr_data),
      .q        (cell_q[i])
    );
  end

  // Result register: the next request can be accepted while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_acc_r  <= dec_acc;
      out_res_r  <= dec_res;
      out_ev_r   <= dec_ev;
      out_slot_r <= slot_field(dec_slot);
      out_evid_r <= id_field(dec_evid);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.was_resident = out_res_r;
  assign out_ch.slot_index   = out_slot_r;
  assign out_ch.evicted      = out_ev_r;
  assign out_ch.evicted_item = out_evid_r;

endmodule

`default_nettype wire

// File: sv/safe_chk.sv
// Port-level checker for the slot allocator and its bind to the top level.
// Depends on safe_pkg and the assertion macros header.
`default_nettype none

`include "slot_allocator_farthest_evict_top_macros.svh"

module safe_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_accepted,
  input logic                              out_was_resident,
  input logic [safe_pkg::SLOT_FIELD_W-1:0] out_slot_index,
  input logic                              out_evicted,
  input logic [safe_pkg::ID_FIELD_W-1:0]   out_evicted_item
);
  import safe_pkg::*;

  // A stalled result keeps its contents.
  `SAFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_accepted, out_was_resident, out_slot_index, out_evicted, out_evicted_item}))

  // A refused request reports nothing else.
  `SAFE_ASSERT_NOW(a_refused_zero, out_valid && !out_accepted, out_slot_index == '0 && !out_was_resident && !out_evicted && out_evicted_item == '0)

  // An eviction only comes with a fresh grant, never with an id already held.
  `SAFE_ASSERT_NOW(a_evict_grant, out_valid && out_evicted, out_accepted && !out_was_resident)

  // The allocator works on one request at a time.
  `SAFE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind slot_allocator_farthest_evict_top safe_chk u_safe_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_was_resident (out_ch.was_resident),
  .out_slot_index   (out_ch.slot_index),
  .out_evicted      (out_ch.evicted),
  .out_evicted_item (out_ch.evicted_item)
);

`default_nettype wire
